// ===== rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared definitions for the max tracking stack
// Request codes, status codes, stack geometry and payload widths.
// ----------------------------------------------------------------------------
package mts_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Payload widths
   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 2 * VALUE_W;

   // Request codes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_PUSH = 2'd0;
   localparam op_type OP_POP  = 2'd1;
   localparam op_type OP_MAX  = 2'd2;

   // Status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [ADDR_W-1:0]         addr_type;

endpackage

// ===== rtl/max_tracking_stack_top.sv =====
// ----------------------------------------------------------------------------
// max_tracking_stack_top: LIFO stack of signed values with maximum report
// Push, pop and maximum requests, one result beat per request.
// ----------------------------------------------------------------------------
// Every stack entry is kept in one RAM as a pair of its value and the running
// maximum of itself and all entries beneath it; the top entry is also cached
// in registers, so push and maximum need no RAM read and a request can be
// taken every cycle unless a refetch or an unaccepted result holds it. A pop
// that leaves the stack non-empty must refetch the new top entry from the
// RAM's registered read port, so the request after such a pop waits while
// the new top is loaded. Pop or maximum on an empty stack answers 0 with the
// empty status; a push onto a full stack is dropped and answers 0 with the
// full status; an unused request code answers 0 with status ok. The result
// register lets a new request be taken while the previous result is taken.
module max_tracking_stack_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mts_pkg::op_type         req_op,
   input  mts_pkg::value_type      req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mts_pkg::value_type      rsp_result_value,
   output mts_pkg::status_type     rsp_status
);
   import mts_pkg::*;

   // Control state
   count_type  count_ff,  count_in;
   logic       refill_ff, refill_in;
   logic       rsp_valid_ff, rsp_valid_in;
   // Payload state
   value_type  top_val_ff, top_val_in;
   value_type  top_max_ff, top_max_in;
   value_type  rsp_value_ff, rsp_value_in;
   status_type rsp_status_ff, rsp_status_in;

   // RAM ports
   logic                 wr_en;
   addr_type             wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic                 rd_en;
   addr_type             rd_addr;
   logic [ENTRY_W-1:0]   rd_data;

   logic      accept;
   logic      is_empty;
   logic      is_full;
   value_type push_max;
   count_type count_less2;

   mts_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(STACK_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Hold requests while refetching the top or while a result is stuck
   assign req_ready = !refill_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign is_empty    = (count_ff == '0);
   assign is_full     = (count_ff == count_type'(STACK_DEPTH));
   assign count_less2 = count_ff - count_type'(2);

   // Running maximum for a new entry
   always_comb begin
      push_max = req_value;
      if (!is_empty && (top_max_ff > req_value)) begin
         push_max = top_max_ff;
      end
   end

   // Request decode, stack update and result formation
   always_comb begin
      count_in      = count_ff;
      refill_in     = 1'b0;
      top_val_in    = top_val_ff;
      top_max_in    = top_max_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_data       = {push_max, req_value};
      rd_en         = 1'b0;
      rd_addr       = count_less2[ADDR_W-1:0];

      // Load the refetched top entry
      if (refill_ff) begin
         top_val_in = rd_data[VALUE_W-1:0];
         top_max_in = rd_data[ENTRY_W-1:VALUE_W];
      end

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         case (req_op)
            OP_PUSH: begin
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  wr_en        = 1'b1;
                  top_val_in   = req_value;
                  top_max_in   = push_max;
                  count_in     = count_ff + count_type'(1);
                  rsp_value_in = req_value;
               end
            end
            OP_POP: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  count_in     = count_ff - count_type'(1);
                  rsp_value_in = top_val_ff;
                  // Fetch the entry beneath when one remains
                  if (count_ff != count_type'(1)) begin
                     rd_en     = 1'b1;
                     refill_in = 1'b1;
                  end
               end
            end
            OP_MAX: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_value_in = top_max_ff;
               end
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         refill_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         refill_ff    <= refill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_val_ff    <= top_val_in;
      top_max_ff    <= top_max_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== rtl/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
